>>> rtl/cv3_pkg.sv
// shared types and constants of the 3x3 valid-region convolution filter
package cv3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int KSIZE          = 3;
  localparam int MIN_SIZE       = 3;
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 8;
  localparam int SUM_W          = 20;
  localparam int PROD_W         = PIX_W + COEF_W + 1;
  localparam int ROW_SUM_W      = PROD_W + 1;
  localparam int FRAME_W        = 11;
  localparam int CFG_W          = KSIZE * COEF_W;
  localparam int CFG_IDX_W      = 3;
  localparam int OUT_DEPTH      = 16;
  localparam int MID_DEPTH      = 2;

  localparam logic [FRAME_W-1:0] WIDTH_RESET  = FRAME_W'(320);
  localparam logic [FRAME_W-1:0] HEIGHT_RESET = FRAME_W'(253);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_TOP   = 3'd2,
    REG_KERNEL_MID   = 3'd3,
    REG_KERNEL_BOT   = 3'd4
  } cfg_reg_t;

  // [row][col][bit], row 0 is the oldest line, col 0 the oldest column
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;
  typedef logic [KSIZE-1:0][CFG_W-1:0] kernel_t;

  typedef struct packed {
    window_t win;
    logic    last;
  } win_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic drop;
  } front_stat_t;

endpackage

>>> rtl/cv3_fifo.sv
// small register queue with push/full and pop/empty sides
module cv3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

>>> rtl/cv3_front.sv
// front end: raster counters, line stores, 3x3 window and result classification
module cv3_front #(
  parameter int MAX_WIDTH  = cv3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [cv3_pkg::PIX_W-1:0]    pixel,
  input  logic [cv3_pkg::FRAME_W-1:0]  frame_width,
  input  logic [cv3_pkg::FRAME_W-1:0]  frame_height,
  output logic                         item_valid,
  output cv3_pkg::win_item_t           item,
  output cv3_pkg::front_stat_t         stat
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int LWA = $clog2(MAX_WIDTH + 1);
  localparam int LHA = $clog2(MAX_HEIGHT + 1);
  localparam int LW  = (LWA > cv3_pkg::FRAME_W) ? LWA : cv3_pkg::FRAME_W;
  localparam int LH  = (LHA > cv3_pkg::FRAME_W) ? LHA : cv3_pkg::FRAME_W;

  logic [cv3_pkg::PIX_W-1:0] line_upper [MAX_WIDTH];
  logic [cv3_pkg::PIX_W-1:0] line_lower [MAX_WIDTH];

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [LW-1:0] fw_ext;
  logic [LH-1:0] fh_ext;
  logic [LW-1:0] w_eff;
  logic [LH-1:0] h_eff;
  logic          row_end;
  logic          frame_end;

  logic [CW-1:0] clr_addr;
  logic          clr_active;

  logic [cv3_pkg::PIX_W-1:0] rd_upper;
  logic [cv3_pkg::PIX_W-1:0] rd_lower;
  logic                      s1_valid;
  logic [CW-1:0]             s1_col;
  logic [cv3_pkg::PIX_W-1:0] s1_px;
  logic                      s1_emit;
  logic                      s1_last;

  cv3_pkg::window_t window;
  logic             out_last;

  // effective frame size saturated to the supported range
  assign fw_ext = LW'(frame_width);
  assign fh_ext = LH'(frame_height);
  assign w_eff  = (fw_ext < LW'(cv3_pkg::MIN_SIZE)) ? LW'(cv3_pkg::MIN_SIZE) :
                  (fw_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : fw_ext;
  assign h_eff  = (fh_ext < LH'(cv3_pkg::MIN_SIZE)) ? LH'(cv3_pkg::MIN_SIZE) :
                  (fh_ext > LH'(MAX_HEIGHT)) ? LH'(MAX_HEIGHT) : fh_ext;

  assign row_end   = (LW'(col) >= (w_eff - LW'(1)));
  assign frame_end = row_end && (LH'(row) >= (h_eff - LH'(1)));

  // line stores: read at accept, written back in the cycle after
  // the next request always sits at another column, so no bypass is needed
  always_ff @(posedge clk) begin
    if (clr_active) begin
      line_upper[clr_addr] <= '0;
      line_lower[clr_addr] <= '0;
    end else if (s1_valid) begin
      line_upper[s1_col] <= rd_lower;
      line_lower[s1_col] <= s1_px;
    end
    if (take) begin
      rd_upper <= line_upper[col];
      rd_lower <= line_lower[col];
    end
  end

  always_ff @(posedge clk) begin
    s1_col  <= col;
    s1_px   <= pixel;
    s1_emit <= (row >= RW'(2)) && (col >= CW'(2));
    s1_last <= frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      clr_addr   <= '0;
      clr_active <= 1'b1;
      s1_valid   <= 1'b0;
      item_valid <= 1'b0;
      out_last   <= 1'b0;
      window     <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + CW'(1);
        if (clr_addr == CW'(MAX_WIDTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (take) begin
        if (row_end) begin
          col <= '0;
          row <= frame_end ? '0 : row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      s1_valid   <= take;
      item_valid <= s1_valid && s1_emit;
      if (s1_valid) begin
        out_last <= s1_last;
        for (int m = 0; m < cv3_pkg::KSIZE; m++) begin
          window[m][0] <= window[m][1];
          window[m][1] <= window[m][2];
        end
        window[0][2] <= rd_upper;
        window[1][2] <= rd_lower;
        window[2][2] <= s1_px;
      end
    end
  end

  assign item.win      = window;
  assign item.last     = out_last;
  assign stat.clearing = clr_active;
  assign stat.drop     = s1_valid && !s1_emit;

endmodule

>>> rtl/cv3_back.sv
// back end: nine products, row sums and the final sum in three stages
module cv3_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  cv3_pkg::win_item_t item,
  input  cv3_pkg::kernel_t   kernel,
  output logic               res_valid,
  output cv3_pkg::res_t      res
);

  localparam int K = cv3_pkg::KSIZE;

  logic signed [cv3_pkg::PROD_W-1:0]    prod [K][K];
  logic signed [cv3_pkg::ROW_SUM_W-1:0] row_sum [K];
  logic                                 a_valid;
  logic                                 a_last;
  logic                                 b_valid;
  logic                                 b_last;

  always_ff @(posedge clk) begin
    for (int m = 0; m < K; m++) begin
      for (int n = 0; n < K; n++) begin
        prod[m][n] <= $signed({1'b0, item.win[m][n]}) *
                      $signed(kernel[m][n*cv3_pkg::COEF_W +: cv3_pkg::COEF_W]);
      end
    end
    for (int m = 0; m < K; m++) begin
      row_sum[m] <= cv3_pkg::ROW_SUM_W'(prod[m][0]) + cv3_pkg::ROW_SUM_W'(prod[m][1]) +
                    cv3_pkg::ROW_SUM_W'(prod[m][2]);
    end
    res.sum  <= cv3_pkg::SUM_W'(row_sum[0]) + cv3_pkg::SUM_W'(row_sum[1]) +
                cv3_pkg::SUM_W'(row_sum[2]);
    a_last   <= item.last;
    b_last   <= a_last;
    res.last <= b_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      a_valid   <= item_valid;
      b_valid   <= a_valid;
      res_valid <= b_valid;
    end
  end

endmodule

>>> rtl/conv3x3_valid_filter_top.sv
// top level of the 3x3 valid-region convolution filter
// Takes one 8-bit pixel per clock in raster order while full is low and
// returns one exact 20-bit correlation sum for every pixel at row >= 2 and
// column >= 2, with frame_last set on the final sum of a frame. Sustained rate
// is one pixel per cycle while results are popped.
// The input side takes pixels as long as fewer than 16 requests that may still
// yield a result are outstanding, which is the depth of the result queue.
// After reset the line stores are cleared one column per cycle, so full stays
// high until every column is clear; configuration writes are taken meanwhile.
module conv3x3_valid_filter_top #(
  parameter int MAX_WIDTH  = cv3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cv3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [cv3_pkg::PIX_W-1:0]           pixel,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [cv3_pkg::SUM_W-1:0]    filtered_sum,
  output logic                                frame_last,
  input  logic                                write_enable,
  input  logic [cv3_pkg::CFG_IDX_W-1:0]       reg_index,
  input  logic [cv3_pkg::CFG_W-1:0]           write_data
);

  localparam int CRW = $clog2(cv3_pkg::OUT_DEPTH + 1);
  localparam int MIW = $bits(cv3_pkg::win_item_t);
  localparam int RSW = $bits(cv3_pkg::res_t);

  logic [cv3_pkg::FRAME_W-1:0] frame_width;
  logic [cv3_pkg::FRAME_W-1:0] frame_height;
  cv3_pkg::kernel_t            kernel;

  logic                 take;
  logic                 front_valid;
  cv3_pkg::win_item_t   front_item;
  cv3_pkg::front_stat_t front_stat;
  logic                 mid_full;
  logic                 mid_empty;
  logic [MIW-1:0]       mid_rdata;
  cv3_pkg::win_item_t   mid_item;
  logic                 back_valid;
  cv3_pkg::res_t        back_res;
  logic                 out_full;
  logic [RSW-1:0]       out_rdata;
  cv3_pkg::res_t        out_res;
  logic                 res_pop;
  logic [CRW-1:0]       credits;
  logic [CRW-1:0]       credits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cv3_pkg::WIDTH_RESET;
      frame_height <= cv3_pkg::HEIGHT_RESET;
      kernel       <= '0;
    end else if (write_enable) begin
      unique case (cv3_pkg::cfg_reg_t'(reg_index))
        cv3_pkg::REG_FRAME_WIDTH:  frame_width  <= write_data[cv3_pkg::FRAME_W-1:0];
        cv3_pkg::REG_FRAME_HEIGHT: frame_height <= write_data[cv3_pkg::FRAME_W-1:0];
        cv3_pkg::REG_KERNEL_TOP:   kernel[0]    <= write_data;
        cv3_pkg::REG_KERNEL_MID:   kernel[1]    <= write_data;
        cv3_pkg::REG_KERNEL_BOT:   kernel[2]    <= write_data;
        default: ;
      endcase
    end
  end

  // every accepted request holds a result slot until it is dropped or popped
  assign full    = front_stat.clearing || (credits >= CRW'(cv3_pkg::OUT_DEPTH));
  assign take    = push && !full;
  assign res_pop = pop && !empty;

  always_comb begin
    credits_next = credits;
    if (take) begin
      credits_next = credits_next + CRW'(1);
    end
    if (front_stat.drop) begin
      credits_next = credits_next - CRW'(1);
    end
    if (res_pop) begin
      credits_next = credits_next - CRW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  cv3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .item_valid   (front_valid),
    .item         (front_item),
    .stat         (front_stat)
  );

  cv3_fifo #(
    .WIDTH (MIW),
    .DEPTH (cv3_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (!mid_empty),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_item = cv3_pkg::win_item_t'(mid_rdata);

  cv3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty && !mid_full),
    .item       (mid_item),
    .kernel     (kernel),
    .res_valid  (back_valid),
    .res        (back_res)
  );

  cv3_fifo #(
    .WIDTH (RSW),
    .DEPTH (cv3_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop && !out_full || res_pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_res      = cv3_pkg::res_t'(out_rdata);
  assign filtered_sum = out_res.sum;
  assign frame_last   = out_res.last;

endmodule
